[hdl/variable_length_record_ring_fifo_macros.svh]
// Assertion macros used by the checker file.
`ifndef VARIABLE_LENGTH_RECORD_RING_FIFO_MACROS_SVH
`define VARIABLE_LENGTH_RECORD_RING_FIFO_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define VLR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication checked in the cycle after the antecedent.
`define VLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hdl/vlrrf_pkg.sv]
// ----------------------------------------------------------------------------
// vlrrf_pkg
// Shared types and constants of the variable-length record ring FIFO.
// ----------------------------------------------------------------------------
package vlrrf_pkg;

    localparam int RING_BYTES_DEF    = 4096;
    localparam int HDR_BYTES_DEF     = 4;
    localparam int CFG_W             = 13;
    localparam int LEN_W             = 12;
    localparam int CNT_W             = 11;
    localparam logic [CFG_W-1:0] RING_LENGTH_RESET = 13'd4096;
    localparam logic [CFG_W-1:0] RING_LENGTH_MIN   = 13'd16;
    localparam logic [CNT_W-1:0] COUNT_MAX         = 11'd2047;

    typedef enum logic [1:0] {
        K_APPEND = 2'd0,
        K_READ   = 2'd1,
        K_REMOVE = 2'd2,
        K_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_END     = 2'd2,
        ST_DROPPED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_HDR_WR,
        S_HDR_RD,
        S_HDR_WAIT,
        S_RD_WAIT,
        S_DONE
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic exec;      // evaluate the accepted item
        logic hdr_wr;    // write one header byte
        logic hdr_rd;    // issue one header byte read
        logic hdr_cap;   // capture the returned header byte
        logic rd_cap;    // capture a data byte
        logic finish;    // load the result register
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic need_hdr_wr;
        logic need_hdr_rd;
        logic need_rd;
        logic hdr_last;
    } t_stat;

endpackage

[hdl/vlrrf_if.sv]
// ----------------------------------------------------------------------------
// vlrrf_in_if / vlrrf_out_if / vlrrf_cfg_if
// Valid-ready channels of the record FIFO.
// ----------------------------------------------------------------------------
interface vlrrf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last_byte;
    modport source (output valid, kind, data_byte, last_byte, input ready);
    modport sink   (input valid, kind, data_byte, last_byte, output ready);
endinterface

interface vlrrf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_byte;
    logic [1:0]  status;
    logic [11:0] bytes_left;
    logic        end_of_record;
    logic [10:0] record_count;
    logic [12:0] free_bytes;
    modport source (output valid, read_byte, status, bytes_left, end_of_record,
                    record_count, free_bytes, input ready);
    modport sink   (input valid, read_byte, status, bytes_left, end_of_record,
                    record_count, free_bytes, output ready);
endinterface

interface vlrrf_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[hdl/vlrrf_ram.sv]
// ----------------------------------------------------------------------------
// vlrrf_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module vlrrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write or read one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[hdl/vlrrf_ctrl.sv]
// ----------------------------------------------------------------------------
// vlrrf_ctrl
// Sequencer for one item: evaluate, header bytes, data read, result.
// ----------------------------------------------------------------------------
module vlrrf_ctrl
    import vlrrf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_fire,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_in_fire) n_state = S_EXEC;
            S_EXEC: begin
                if (i_stat.need_hdr_wr)      n_state = S_HDR_WR;
                else if (i_stat.need_hdr_rd) n_state = S_HDR_RD;
                else if (i_stat.need_rd)     n_state = S_RD_WAIT;
                else                         n_state = S_DONE;
            end
            S_HDR_WR:   if (i_stat.hdr_last) n_state = S_DONE;
            S_HDR_RD:   n_state = S_HDR_WAIT;
            S_HDR_WAIT: n_state = i_stat.hdr_last ? S_DONE : S_HDR_RD;
            S_RD_WAIT:  n_state = S_DONE;
            S_DONE:     if (i_out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE:     o_in_ready = 1'b1;
            S_EXEC:     o_cmd.exec = 1'b1;
            S_HDR_WR:   o_cmd.hdr_wr = 1'b1;
            S_HDR_RD:   o_cmd.hdr_rd = 1'b1;
            S_HDR_WAIT: o_cmd.hdr_cap = 1'b1;
            S_RD_WAIT:  o_cmd.rd_cap = 1'b1;
            S_DONE:     o_cmd.finish = i_out_free;
            default:    o_in_ready = 1'b0;
        endcase
    end
endmodule

[hdl/vlrrf_dp.sv]
// ----------------------------------------------------------------------------
// vlrrf_dp
// Queue pointers, ring memory access and result assembly.
// ----------------------------------------------------------------------------
module vlrrf_dp
    import vlrrf_pkg::*;
#(
    parameter int RING_BYTES = RING_BYTES_DEF,
    parameter int HDR_BYTES  = HDR_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_fire,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_cfg_fire,
    input  logic [12:0] i_cfg_data,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic [7:0]  o_read_byte,
    output logic [1:0]  o_status,
    output logic [11:0] o_bytes_left,
    output logic        o_end_of_record,
    output logic [10:0] o_record_count,
    output logic [12:0] o_free_bytes
);
    localparam int AW = $clog2(RING_BYTES);
    localparam int PW = AW + 1;
    localparam int HW = (HDR_BYTES > 1) ? $clog2(HDR_BYTES) : 1;
    localparam logic [PW-1:0] HDR_P = PW'(HDR_BYTES);
    localparam logic [PW-1:0] RB_P  = PW'(RING_BYTES);

    // Item registers.
    logic [1:0] r_kind;
    logic [7:0] r_data;
    logic       r_last;
    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_kind <= i_kind;
            r_data <= i_data_byte;
            r_last <= i_last_byte;
        end
    end

    // Queue state.
    logic [CFG_W-1:0] r_ring_len;
    logic [PW-1:0]    r_first, r_lastp, r_elen, r_nlen, r_cursor, r_remain;
    logic [PW-1:0]    r_astart, r_acount, r_used;
    logic [CNT_W-1:0] r_count;
    logic             r_drop;
    logic [HW-1:0]    r_hidx;
    logic [PW-1:0]    r_hbase, r_hlen, r_newlen;
    logic [7:0]       r_rbyte;
    logic [1:0]       r_st;
    logic             r_eor;

    // Effective ring length.
    logic [PW-1:0] w_len;
    always_comb begin
        if (r_ring_len < RING_LENGTH_MIN)          w_len = PW'(RING_LENGTH_MIN);
        else if (int'(r_ring_len) > RING_BYTES)    w_len = RB_P;
        else                                       w_len = PW'(r_ring_len);
    end

    // Wrap for operands below twice the length.
    function automatic logic [PW-1:0] f_wrap(input logic [PW:0] p,
                                             input logic [PW-1:0] l);
        logic [PW:0] d;
        d = p - {1'b0, l};
        return (p >= {1'b0, l}) ? d[PW-1:0] : p[PW-1:0];
    endfunction

    logic [PW-1:0] w_free, w_next_start, w_astart_eff, w_wpos, w_next_rec;
    logic          w_fresh, w_nofit;
    assign w_free       = w_len - r_used;
    assign w_fresh      = (r_acount == '0) && !r_drop;
    assign w_next_start = f_wrap({1'b0, r_lastp} + {1'b0,
                          f_wrap({1'b0, HDR_P} + {1'b0, r_nlen}, w_len)}, w_len);
    assign w_astart_eff = !w_fresh ? r_astart : (r_count == '0 ? '0 : w_next_start);
    assign w_nofit      = ({1'b0, HDR_P} + {1'b0, r_acount} + 1'b1 > {1'b0, w_free})
                          || (r_count >= COUNT_MAX);
    assign w_wpos       = f_wrap({1'b0, w_astart_eff} + {1'b0,
                          f_wrap({1'b0, HDR_P} + {1'b0, r_acount}, w_len)}, w_len);
    assign w_next_rec   = f_wrap({1'b0, r_first} + {1'b0,
                          f_wrap({1'b0, HDR_P} + {1'b0, r_elen}, w_len)}, w_len);

    // Memory port selection.
    logic          w_we;
    logic [AW-1:0] w_addr;
    logic [7:0]    w_wdata, w_rdata;
    logic [PW-1:0] w_hpos;
    logic [4:0]    w_sh;
    assign w_hpos = f_wrap({1'b0, r_hbase} + {{(PW-HW){1'b0}}, r_hidx}, w_len);
    assign w_sh   = 5'(8 * (HDR_BYTES - 1)) - {r_hidx, 3'b000};
    always_comb begin
        w_we    = 1'b0;
        w_addr  = r_cursor[AW-1:0];
        w_wdata = r_data;
        if (i_cmd.exec && r_kind == K_APPEND && !r_drop && !w_nofit) begin
            w_we   = 1'b1;
            w_addr = w_wpos[AW-1:0];
        end else if (i_cmd.hdr_wr) begin
            w_we    = 1'b1;
            w_addr  = w_hpos[AW-1:0];
            w_wdata = 8'(32'(r_newlen) >> w_sh);
        end else if (i_cmd.hdr_rd) begin
            w_addr = w_hpos[AW-1:0];
        end
    end

    vlrrf_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    logic w_hlast;
    assign w_hlast = (r_hidx == HW'(HDR_BYTES - 1));

    // Status toward the sequencer, valid during evaluation.
    always_comb begin
        o_stat.need_hdr_wr = i_cmd.exec && r_kind == K_APPEND && !r_drop && !w_nofit
                             && r_last;
        o_stat.need_hdr_rd = i_cmd.exec && r_kind == K_REMOVE && r_count > 11'd1;
        o_stat.need_rd     = i_cmd.exec && r_kind == K_READ && r_count != '0
                             && r_remain != '0;
        o_stat.hdr_last    = w_hlast;
    end

    // State update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_len <= RING_LENGTH_RESET;
            r_first <= '0; r_lastp <= '0; r_elen <= '0; r_nlen <= '0;
            r_count <= '0; r_used <= '0; r_cursor <= '0; r_remain <= '0;
            r_astart <= '0; r_acount <= '0; r_drop <= 1'b0;
            r_hidx <= '0;
        end else if (i_cfg_fire) begin
            r_ring_len <= i_cfg_data;
            r_first <= '0; r_lastp <= '0; r_elen <= '0; r_nlen <= '0;
            r_count <= '0; r_used <= '0; r_cursor <= '0; r_remain <= '0;
            r_astart <= '0; r_acount <= '0; r_drop <= 1'b0;
        end else begin
            if (i_in_fire) begin
                r_rbyte <= '0; r_st <= ST_OK; r_eor <= 1'b0; r_hidx <= '0;
            end
            if (i_cmd.exec) begin
                case (r_kind)
                    K_APPEND: begin
                        if (r_drop || w_nofit) begin
                            r_st <= ST_DROPPED;
                            r_drop <= !r_last;
                            if (r_last) begin
                                r_astart <= '0; r_acount <= '0;
                            end else begin
                                r_astart <= w_astart_eff;
                            end
                        end else if (r_last) begin
                            r_hbase  <= w_astart_eff;
                            r_newlen <= r_acount + 1'b1;
                            r_acount <= '0; r_astart <= '0;
                        end else begin
                            r_astart <= w_astart_eff;
                            r_acount <= r_acount + 1'b1;
                        end
                    end
                    K_READ: begin
                        if (r_count == '0) r_st <= ST_EMPTY;
                        else if (r_remain == '0) r_st <= ST_END;
                        else begin
                            r_cursor <= f_wrap({1'b0, r_cursor} + 1'b1, w_len);
                            r_remain <= r_remain - 1'b1;
                            r_eor    <= (r_remain == PW'(1));
                        end
                    end
                    K_REMOVE: begin
                        if (r_count == '0) r_st <= ST_EMPTY;
                        else if (r_count == 11'd1) begin
                            r_first <= '0; r_lastp <= '0; r_elen <= '0; r_nlen <= '0;
                            r_count <= '0; r_used <= '0; r_cursor <= '0;
                            r_remain <= '0;
                        end else begin
                            r_used  <= r_used - HDR_P - r_elen;
                            r_count <= r_count - 1'b1;
                            r_first <= w_next_rec;
                            r_hbase <= w_next_rec;
                            r_hlen  <= '0;
                        end
                    end
                    default: begin
                        r_first <= '0; r_lastp <= '0; r_elen <= '0; r_nlen <= '0;
                        r_count <= '0; r_used <= '0; r_cursor <= '0; r_remain <= '0;
                        r_astart <= '0; r_acount <= '0; r_drop <= 1'b0;
                    end
                endcase
            end
            // Header write; commit on its final byte.
            if (i_cmd.hdr_wr) begin
                r_hidx <= r_hidx + 1'b1;
                if (w_hlast) begin
                    if (r_count == '0) begin
                        r_first  <= r_hbase;
                        r_elen   <= r_newlen;
                        r_cursor <= f_wrap({1'b0, r_hbase} + {1'b0, HDR_P}, w_len);
                        r_remain <= r_newlen;
                    end
                    r_lastp <= r_hbase;
                    r_nlen  <= r_newlen;
                    r_count <= r_count + 1'b1;
                    r_used  <= r_used + HDR_P + r_newlen;
                end
            end
            // Header read of the next eldest record.
            if (i_cmd.hdr_cap) begin
                r_hidx <= r_hidx + 1'b1;
                r_hlen <= PW'({r_hlen, w_rdata});
                if (w_hlast) begin
                    r_elen   <= PW'({r_hlen, w_rdata});
                    r_remain <= PW'({r_hlen, w_rdata});
                    r_cursor <= f_wrap({1'b0, r_hbase} + {1'b0, HDR_P}, w_len);
                end
            end
            if (i_cmd.rd_cap) r_rbyte <= w_rdata;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_read_byte     <= r_rbyte;
            o_status        <= r_st;
            o_bytes_left    <= (r_count == '0) ? '0 : LEN_W'(r_remain);
            o_end_of_record <= r_eor;
            o_record_count  <= r_count;
            o_free_bytes    <= CFG_W'(w_free);
        end
    end
endmodule

[hdl/variable_length_record_ring_fifo.sv]
// Sequence: each accepted item is evaluated; then a read that returns a byte captures
// it, a committing append writes its header bytes and a remove that loads the next
// header reads its header bytes; the result register is loaded when the output is free.
// Throughput: one item at a time, set by the single byte-wide ring port; the next
// is accepted once the result is registered and the sequencer is back in idle.
// Reset: synchronous active low; queue empty, ring length 4096, memory undefined.
// ----------------------------------------------------------------------------
// variable_length_record_ring_fifo
// Queue of length-prefixed records in a byte-wide ring memory.
// ----------------------------------------------------------------------------
module variable_length_record_ring_fifo
    import vlrrf_pkg::*;
#(
    parameter int RING_BYTES = RING_BYTES_DEF,
    parameter int HDR_BYTES  = HDR_BYTES_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    vlrrf_in_if.sink    in_ch,
    vlrrf_out_if.source out_ch,
    vlrrf_cfg_if.sink   cfg_ch
);
    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready, w_in_fire, w_out_free, r_ovalid;

    // A pending register write takes precedence over a new item.
    assign in_ch.ready  = w_in_ready && !cfg_ch.valid;
    assign w_in_fire    = in_ch.valid && in_ch.ready;
    assign cfg_ch.ready = w_in_ready;
    assign w_out_free   = !r_ovalid || out_ch.ready;
    assign out_ch.valid = r_ovalid;

    // Output valid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_cmd.finish) begin
            r_ovalid <= 1'b1;
        end else if (out_ch.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    vlrrf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_fire (w_in_fire),
        .i_out_free(w_out_free),
        .i_stat    (w_stat),
        .o_in_ready(w_in_ready),
        .o_cmd     (w_cmd)
    );

    vlrrf_dp #(.RING_BYTES(RING_BYTES), .HDR_BYTES(HDR_BYTES)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_fire      (w_in_fire),
        .i_kind         (in_ch.kind),
        .i_data_byte    (in_ch.data_byte),
        .i_last_byte    (in_ch.last_byte),
        .i_cfg_fire     (cfg_ch.valid && cfg_ch.ready),
        .i_cfg_data     (cfg_ch.data),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_read_byte    (out_ch.read_byte),
        .o_status       (out_ch.status),
        .o_bytes_left   (out_ch.bytes_left),
        .o_end_of_record(out_ch.end_of_record),
        .o_record_count (out_ch.record_count),
        .o_free_bytes   (out_ch.free_bytes)
    );
endmodule

[hdl/vlrrf_checker.sv]
// ----------------------------------------------------------------------------
// vlrrf_checker
// Port-level checks of the record FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`include "variable_length_record_ring_fifo_macros.svh"
module vlrrf_checker
    import vlrrf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_status,
    input logic        out_eor,
    input logic [10:0] out_count
);
    `VLR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid, "result dropped")
    `VLR_ASSERT_IMP(a_eor, i_clk, i_rst_n, out_valid && out_eor, out_status == ST_OK, "bad eor")
    `VLR_ASSERT_IMP(a_empty, i_clk, i_rst_n, out_valid && out_status == ST_END, out_count != '0, "end on empty")
    `VLR_ASSERT_NEXT(a_one, i_clk, i_rst_n, in_valid && in_ready, !in_ready, "second item taken")
endmodule

bind variable_length_record_ring_fifo vlrrf_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_status(out_ch.status),
    .out_eor   (out_ch.end_of_record),
    .out_count (out_ch.record_count)
);
